// File: design/sfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfir_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEFF_BITS     = 18;
  localparam int FRAC_BITS      = 14;
  localparam int RADIUS_BITS    = 3;
  localparam int NUM_SIDE       = 5;
  localparam int MAX_RADIUS_DEF = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 5;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = RADIUS_BITS'(1);
  localparam logic [COEFF_BITS-1:0]  CENTER_RST = COEFF_BITS'(16384);

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_ODD_MODE,
    REG_COEFF_CENTER,
    REG_COEFF_SIDE1,
    REG_COEFF_SIDE2,
    REG_COEFF_SIDE3,
    REG_COEFF_SIDE4,
    REG_COEFF_SIDE5
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          last_of_line;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  function automatic int acc_bits(input int max_radius);
    return SAMPLE_BITS + COEFF_BITS + 1 + $clog2(2 * max_radius + 2);
  endfunction

endpackage

`default_nettype wire

// File: design/sfir_tap_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sfir_tap_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift,
  input  logic [sfir_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                             in_flag,
  input  logic [sfir_pkg::SAMPLE_BITS-1:0] first,
  output logic [sfir_pkg::SAMPLE_BITS-1:0] sample,
  output logic                             flag,
  output logic [sfir_pkg::SAMPLE_BITS-1:0] op
);
  import sfir_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   flag_r, flag_nxt;

  always_comb begin
    sample_nxt = shift ? in_sample : sample_r;
    flag_nxt   = shift ? in_flag : flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  assign sample = sample_r;
  assign flag   = flag_r;
  // samples from before the line start read as the first sample
  assign op     = flag_r ? sample_r : first;

endmodule

`default_nettype wire

// File: design/sfir_mac_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sfir_mac_cell #(
  parameter int MAX_RADIUS = sfir_pkg::MAX_RADIUS_DEF,
  parameter int IDX        = 0
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                      r_eff,
  input  logic                                                 odd,
  input  logic [sfir_pkg::COEFF_BITS-1:0]                      center,
  input  logic [sfir_pkg::NUM_SIDE-1:0][sfir_pkg::COEFF_BITS-1:0] side,
  input  sfir_pkg::ctl_t                                       in_ctl,
  input  logic signed [sfir_pkg::acc_bits(MAX_RADIUS)-1:0]     in_acc,
  input  logic [2*MAX_RADIUS:0][sfir_pkg::SAMPLE_BITS-1:0]     in_ops,
  input  logic                                                 dn_ready,
  output logic                                                 up_ready,
  output sfir_pkg::ctl_t                                       out_ctl,
  output logic signed [sfir_pkg::acc_bits(MAX_RADIUS)-1:0]     out_acc,
  output logic [2*MAX_RADIUS:0][sfir_pkg::SAMPLE_BITS-1:0]     out_ops
);
  import sfir_pkg::*;

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int IW    = $clog2(WIN);
  localparam int ACC_W = acc_bits(MAX_RADIUS);

  logic [IW-1:0]                      pos_c, r_c, tap_dist;
  logic signed [COEFF_BITS:0]         side_sel, coef_nxt, coef_r;
  logic signed [COEFF_BITS+SAMPLE_BITS:0] prod;
  logic signed [ACC_W-1:0]            acc_nxt, acc_r;
  logic [WIN-1:0][SAMPLE_BITS-1:0]    ops_r;
  ctl_t                               ctl_r, ctl_nxt;
  logic                               load;

  // tap weight of this window cell for the radius and mode in use
  always_comb begin
    pos_c    = IW'(IDX);
    r_c      = IW'(r_eff);
    tap_dist = (pos_c > r_c) ? pos_c - r_c : r_c - pos_c;
    side_sel = '0;
    for (int k = 0; k < NUM_SIDE; k++) begin
      if (int'(tap_dist) == k + 1) begin
        side_sel = {side[k][COEFF_BITS-1], side[k]};
      end
    end
    priority if (pos_c == r_c) begin
      coef_nxt = {center[COEFF_BITS-1], center};
    end else if (pos_c < r_c) begin
      coef_nxt = side_sel;
    end else if (tap_dist <= r_c) begin
      coef_nxt = odd ? -side_sel : side_sel;
    end else begin
      coef_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  always_comb begin
    prod     = coef_r * $signed(in_ops[IDX]);
    acc_nxt  = in_acc + ACC_W'(prod);
    up_ready = !ctl_r.vld || dn_ready;
    ctl_nxt  = up_ready ? in_ctl : ctl_r;
    load     = up_ready && in_ctl.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= acc_nxt;
      ops_r <= in_ops;
    end
  end

  assign out_ctl = ctl_r;
  assign out_acc = acc_r;
  assign out_ops = ops_r;

endmodule

`default_nettype wire

// File: design/symmetric_fir_line_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Symmetric FIR line filter with edge replication. Samples of an image line enter one per
// cycle on the in_ channel while in_stall is low; each result for position p leaves once
// sample p+R has been taken, and the item marked line_end releases the rest of the line's
// outputs. Inside the line an item is accepted every cycle unless the output stalls. After
// a line_end item the input stalls (R = radius in use, at most MAX_RADIUS) while the window
// line replicates the last sample and the remaining results, at most R+1, are issued one per
// cycle unless the output stalls. The first result of an item is registered in turn by the
// window at the accepting edge, then by the issue register, each of the 2*MAX_RADIUS+1
// multiply-accumulate cells and the output register. On a line end of a line shorter than
// R+1 samples the padding cycles come first; further results follow one per cycle if unstalled.
// Registers (APB, byte address 4*i): 0 radius, 1 odd_mode, 2 coeff_center, 3..7 coeff_side1..5;
// coefficients are signed Q4.14. Radius above MAX_RADIUS acts as MAX_RADIUS. Results are
// rounded to nearest (ties upward) and saturated to 16-bit signed.

module symmetric_fir_line_filter #(
  parameter int MAX_RADIUS = sfir_pkg::MAX_RADIUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sfir_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sfir_pkg::out_item_t                out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sfir_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [sfir_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [sfir_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sfir_pkg::*;

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int ACC_W = acc_bits(MAX_RADIUS);

  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [SAMPLE_BITS-1:0]  OUT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0]  OUT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration registers
  logic [RADIUS_BITS-1:0]               radius_r, radius_nxt;
  logic                                 odd_r, odd_nxt;
  logic [COEFF_BITS-1:0]                center_r, center_nxt;
  logic [NUM_SIDE-1:0][COEFF_BITS-1:0]  side_r, side_nxt;
  logic                                 cfg_wr;
  reg_idx_t                             cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    radius_nxt = radius_r;
    odd_nxt    = odd_r;
    center_nxt = center_r;
    side_nxt   = side_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS:       radius_nxt  = pwdata[RADIUS_BITS-1:0];
        REG_ODD_MODE:     odd_nxt     = pwdata[0];
        REG_COEFF_CENTER: center_nxt  = pwdata[COEFF_BITS-1:0];
        REG_COEFF_SIDE1:  side_nxt[0] = pwdata[COEFF_BITS-1:0];
        REG_COEFF_SIDE2:  side_nxt[1] = pwdata[COEFF_BITS-1:0];
        REG_COEFF_SIDE3:  side_nxt[2] = pwdata[COEFF_BITS-1:0];
        REG_COEFF_SIDE4:  side_nxt[3] = pwdata[COEFF_BITS-1:0];
        REG_COEFF_SIDE5:  side_nxt[4] = pwdata[COEFF_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      odd_r    <= 1'b0;
      center_r <= CENTER_RST;
      side_r   <= '0;
    end else begin
      radius_r <= radius_nxt;
      odd_r    <= odd_nxt;
      center_r <= center_nxt;
      side_r   <= side_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS:       prdata = CFG_DATA_BITS'(radius_r);
      REG_ODD_MODE:     prdata = CFG_DATA_BITS'(odd_r);
      REG_COEFF_CENTER: prdata = CFG_DATA_BITS'(center_r);
      REG_COEFF_SIDE1:  prdata = CFG_DATA_BITS'(side_r[0]);
      REG_COEFF_SIDE2:  prdata = CFG_DATA_BITS'(side_r[1]);
      REG_COEFF_SIDE3:  prdata = CFG_DATA_BITS'(side_r[2]);
      REG_COEFF_SIDE4:  prdata = CFG_DATA_BITS'(side_r[3]);
      REG_COEFF_SIDE5:  prdata = CFG_DATA_BITS'(side_r[4]);
    endcase
  end

  // line sequencing
  logic [RW-1:0]          r_eff, m_new;
  logic [RW-1:0]          pos_r, pos_nxt;
  logic [RW-1:0]          left_r, left_nxt;
  logic [RW-1:0]          thr_r, thr_nxt;
  logic                   busy_r, busy_nxt;
  logic                   tail_r, tail_nxt;
  logic [SAMPLE_BITS-1:0] first_r, first_nxt;
  logic                   emit, step, accept, shift, keep, job_ready;

  assign r_eff = (int'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_r);
  assign m_new = (r_eff < pos_r) ? r_eff : pos_r;

  always_comb begin
    emit     = busy_r && (left_r <= thr_r);
    step     = busy_r && (!emit || job_ready);
    in_stall = busy_r && !(step && (left_r == '0));
    accept   = in_valid && !in_stall;
    // while left_r is nonzero the line end is padded with copies of the last sample
    shift    = accept || (step && (left_r != '0));
    keep     = !(accept && (pos_r == '0));
  end

  always_comb begin
    busy_nxt  = busy_r;
    tail_nxt  = tail_r;
    left_nxt  = left_r;
    thr_nxt   = thr_r;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    priority if (accept) begin
      tail_nxt = in_item.line_end;
      if (in_item.line_end) begin
        busy_nxt = 1'b1;
        left_nxt = r_eff;
        thr_nxt  = m_new;
        pos_nxt  = '0;
      end else begin
        busy_nxt = (r_eff <= pos_r);
        left_nxt = '0;
        thr_nxt  = '0;
        pos_nxt  = (pos_r == RW'(MAX_RADIUS)) ? pos_r : pos_r + RW'(1);
      end
      if (pos_r == '0) begin
        first_nxt = in_item.sample;
      end
    end else if (step) begin
      if (left_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        left_nxt = left_r - RW'(1);
      end
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tail_r <= 1'b0;
      left_r <= '0;
      thr_r  <= '0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      tail_r <= tail_nxt;
      left_r <= left_nxt;
      thr_r  <= thr_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

  // window line, newest sample in cell 0
  logic [WIN-1:0][SAMPLE_BITS-1:0] w_sample, w_op;
  logic [WIN-1:0]                  w_flag;

  sfir_tap_cell u_tap0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (shift),
    .in_sample (accept ? in_item.sample : w_sample[0]),
    .in_flag   (1'b1),
    .first     (first_r),
    .sample    (w_sample[0]),
    .flag      (w_flag[0]),
    .op        (w_op[0])
  );

  for (genvar k = 1; k < WIN; k++) begin : g_tap
    sfir_tap_cell u_tap (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .in_sample (w_sample[k-1]),
      .in_flag   (w_flag[k-1] && keep),
      .first     (first_r),
      .sample    (w_sample[k]),
      .flag      (w_flag[k]),
      .op        (w_op[k])
    );
  end

  // issue register
  ctl_t                            job_ctl_r, job_ctl_nxt;
  logic [WIN-1:0][SAMPLE_BITS-1:0] job_ops_r;
  logic [WIN:0]                    st_rdy;

  assign job_ready = !job_ctl_r.vld || st_rdy[0];

  always_comb begin
    job_ctl_nxt = job_ctl_r;
    if (job_ready) begin
      job_ctl_nxt = '{vld: emit, last: tail_r && (left_r == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_ctl_r <= '0;
    end else begin
      job_ctl_r <= job_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && emit) begin
      job_ops_r <= w_op;
    end
  end

  // multiply-accumulate row
  ctl_t                            st_ctl [WIN+1];
  logic signed [ACC_W-1:0]         st_acc [WIN+1];
  logic [WIN-1:0][SAMPLE_BITS-1:0] st_ops [WIN+1];
  logic                            out_adv;

  assign st_ctl[0]   = job_ctl_r;
  assign st_acc[0]   = ROUND;
  assign st_ops[0]   = job_ops_r;
  assign st_rdy[WIN] = out_adv;

  for (genvar k = 0; k < WIN; k++) begin : g_mac
    sfir_mac_cell #(
      .MAX_RADIUS (MAX_RADIUS),
      .IDX        (k)
    ) u_mac (
      .clk      (clk),
      .rst_n    (rst_n),
      .r_eff    (r_eff),
      .odd      (odd_r),
      .center   (center_r),
      .side     (side_r),
      .in_ctl   (st_ctl[k]),
      .in_acc   (st_acc[k]),
      .in_ops   (st_ops[k]),
      .dn_ready (st_rdy[k+1]),
      .up_ready (st_rdy[k]),
      .out_ctl  (st_ctl[k+1]),
      .out_acc  (st_acc[k+1]),
      .out_ops  (st_ops[k+1])
    );
  end

  // round, saturate, output register
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;
  logic signed [ACC_W-1:0] shifted;

  assign out_adv = !out_valid_r || !out_stall;

  always_comb begin
    shifted       = st_acc[WIN] >>> FRAC_BITS;
    out_valid_nxt = out_adv ? st_ctl[WIN].vld : out_valid_r;
    out_item_nxt.last_of_line = st_ctl[WIN].last;
    priority if (shifted > SAT_HI) begin
      out_item_nxt.filtered = OUT_HI;
    end else if (shifted < SAT_LO) begin
      out_item_nxt.filtered = OUT_LO;
    end else begin
      out_item_nxt.filtered = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && st_ctl[WIN].vld) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
